/* rtl/bwc_pkg.sv */
// Package for the compact-to-work block: widths, decode constants and the
// item that the front end hands to the divider. No dependencies.
`default_nettype none

package bwc_pkg;

  localparam int unsigned CompactW = 32;
  localparam int unsigned ExpoW    = 8;
  localparam int unsigned MantW    = 23;
  localparam int unsigned SignBit  = 23;
  localparam int unsigned WorkW    = 256;
  localparam int unsigned WordW    = 64;
  localparam int unsigned DivSteps = WorkW;

  // Exponent that leaves the mantissa where it is.
  localparam logic [ExpoW-1:0] ExpoBias = 8'd3;
  // Exponent limits past which a nonzero mantissa no longer fits.
  localparam logic [ExpoW-1:0] ExpoMaxByte  = 8'd34;
  localparam logic [ExpoW-1:0] ExpoMaxShort = 8'd33;
  localparam logic [ExpoW-1:0] ExpoMaxWide  = 8'd32;
  localparam logic [MantW-1:0] MantByteMax  = 23'h0000ff;
  localparam logic [MantW-1:0] MantShortMax = 23'h00ffff;

  // One decoded item: divisor is target + 1, live starts the remainder at
  // one (clear for a zero target or an overflowed word, which give work 0).
  typedef struct packed {
    logic [WorkW-1:0] divisor;
    logic             live;
    logic             over;
  } bwc_item_t;

endpackage

`default_nettype wire

/* rtl/bwc_front.sv */
// Front end: decodes a compact word into divisor and flags and holds it
// until the queue takes it. Depends on bwc_pkg.
`default_nettype none

module bwc_front
  import bwc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire logic [CompactW-1:0] compact_bits_i,
  output      logic                ready_o,
  output      logic                valid_o,
  output      bwc_item_t           item_o,
  input  wire logic                taken_i
);

  logic [ExpoW-1:0] expo;
  logic [MantW-1:0] mant;
  logic [MantW-1:0] mant_s;
  logic [ExpoW-1:0] shift_bytes;
  logic [WorkW-1:0] target;
  logic             nz;
  logic             over;
  bwc_item_t        item_d;
  bwc_item_t        item_q;
  logic             valid_q;
  logic             load;

  always_comb begin
    expo        = compact_bits_i[CompactW-1 -: ExpoW];
    mant        = compact_bits_i[MantW-1:0];
    shift_bytes = expo - ExpoBias;
    mant_s      = mant;
    target      = WorkW'(mant);
    if (expo <= ExpoBias) begin
      unique case (expo[1:0])
        2'd0: mant_s = '0;
        2'd1: mant_s = mant >> 16;
        2'd2: mant_s = mant >> 8;
        2'd3: mant_s = mant;
      endcase
      target = WorkW'(mant_s);
    end else begin
      target = WorkW'(mant) << {shift_bytes, 3'b000};
    end
    nz   = (mant_s != '0);
    over = nz && (compact_bits_i[SignBit] ||
                  (expo > ExpoMaxByte) ||
                  ((mant_s > MantByteMax) && (expo > ExpoMaxShort)) ||
                  ((mant_s > MantShortMax) && (expo > ExpoMaxWide)));
    item_d.divisor = target + WorkW'(1);
    item_d.live    = nz && !over;
    item_d.over    = over;
  end

  // Load when empty or when the held item leaves this cycle.
  assign ready_o = !valid_q || taken_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/bwc_queue.sv */
// Short item queue between front end and divider.
// Depends on bwc_pkg.
`default_nettype none

module bwc_queue
  import bwc_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire bwc_item_t item_i,
  output      logic      full_o,
  output      logic      valid_o,
  output      bwc_item_t item_o,
  input  wire logic      pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bwc_item_t       slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTH
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue written while full");
  a_count_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule

`default_nettype wire

/* rtl/bwc_div.sv */
// Divider back end: 2^256 / divisor, one quotient bit per pipeline step,
// restoring form. Depends on bwc_pkg.
`default_nettype none

module bwc_div
  import bwc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire bwc_item_t        item_i,
  output      logic             done_o,
  output      logic [WorkW-1:0] work_o,
  output      logic             over_o
);

  logic             vld_q [DivSteps];
  logic [WorkW-1:0] rem_q [DivSteps];
  logic [WorkW-1:0] dvs_q [DivSteps];
  logic [WorkW-1:0] quo_q [DivSteps];
  logic             ovf_q [DivSteps];

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic             vin;
    logic [WorkW-1:0] rin;
    logic [WorkW-1:0] din;
    logic [WorkW-1:0] qin;
    logic             oin;
    logic [WorkW:0]   shl;
    logic [WorkW+1:0] diff;
    logic             take;

    if (s == 0) begin : g_first
      // The leading one of 2^256 is already in the remainder.
      assign vin = valid_i;
      assign rin = WorkW'(item_i.live);
      assign din = item_i.divisor;
      assign qin = '0;
      assign oin = item_i.over;
    end else begin : g_next
      assign vin = vld_q[s-1];
      assign rin = rem_q[s-1];
      assign din = dvs_q[s-1];
      assign qin = quo_q[s-1];
      assign oin = ovf_q[s-1];
    end

    // Shift in a zero dividend bit, subtract when it fits.
    assign shl  = {rin, 1'b0};
    assign diff = {1'b0, shl} - {2'b00, din};
    assign take = !diff[WorkW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= take ? diff[WorkW-1:0] : shl[WorkW-1:0];
      dvs_q[s] <= din;
      quo_q[s] <= qin | (WorkW'(take) << (DivSteps - 1 - s));
      ovf_q[s] <= oin;
    end
  end

  assign done_o = vld_q[DivSteps-1];
  assign work_o = quo_q[DivSteps-1];
  assign over_o = ovf_q[DivSteps-1];

endmodule

`default_nettype wire

/* rtl/block_work_from_compact.sv */
// Top level of the compact-to-work block: front end, item queue, divider.
// Depends on bwc_pkg, bwc_front, bwc_queue and bwc_div.
`default_nettype none

// Expands a 32-bit compact difficulty word into its 256-bit target and
// returns the work 2^256 / (target + 1), modulo 2^256, as four 64-bit words
// plus an overflow flag. A word with a nonzero mantissa that is negative or
// too large for 256 bits returns work 0 with bits_overflowed_o set; a zero
// target returns work 0 with the flag clear. An item is taken on every clock
// edge with start_i high and busy_o low, and one item can follow another in
// every cycle. Each item gives exactly one result, shown for one cycle with
// done_o high, in the order the items came in; the receiver cannot stall it.
// From accept to done_o an item passes the decode register holding the word
// decoded into a divisor, the item queue and the 256 steps of the pipelined
// restoring divider, one quotient bit per step. The divider never stalls, so
// the queue drains every cycle and busy_o stays low in normal operation; it
// only rises if the queue and the decode register both hold an item.

module block_work_from_compact
  import bwc_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [CompactW-1:0] compact_bits_i,
  output      logic                busy_o,
  output      logic                done_o,
  output      logic [WordW-1:0]    work_word0_o,
  output      logic [WordW-1:0]    work_word1_o,
  output      logic [WordW-1:0]    work_word2_o,
  output      logic [WordW-1:0]    work_word3_o,
  output      logic                bits_overflowed_o
);

  logic             front_ready;
  logic             front_valid;
  bwc_item_t        front_item;
  logic             queue_full;
  logic             queue_valid;
  bwc_item_t        queue_item;
  logic             push;
  logic [WorkW-1:0] work;

  // Decode the compact word and hold it until the queue has room.
  bwc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (start_i),
    .compact_bits_i (compact_bits_i),
    .ready_o        (front_ready),
    .valid_o        (front_valid),
    .item_o         (front_item),
    .taken_i        (push)
  );

  assign push   = front_valid && !queue_full;
  assign busy_o = !front_ready;

  bwc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .item_o  (queue_item),
    .pop_i   (queue_valid)
  );

  // Advance every cycle: the divider takes the queue head whenever present.
  bwc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (queue_valid),
    .item_i  (queue_item),
    .done_o  (done_o),
    .work_o  (work),
    .over_o  (bits_overflowed_o)
  );

  assign work_word0_o = work[WordW-1:0];
  assign work_word1_o = work[2*WordW-1:WordW];
  assign work_word2_o = work[3*WordW-1:2*WordW];
  assign work_word3_o = work[4*WordW-1:3*WordW];

`ifndef SYNTH
  a_over_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bits_overflowed_o) |->
      (work_word0_o == '0 && work_word1_o == '0 &&
       work_word2_o == '0 && work_word3_o == '0))
    else $error("overflowed item returned nonzero work");
  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("item queue backed up although the divider never stalls");
`endif

endmodule

`default_nettype wire
